// ----- hw/rtl/jbht_pkg.sv -----
`timescale 1ns / 1ps

package jbht_pkg;

  // queue and reply limits
  localparam int unsigned TxBytesMax = 8;
  localparam int unsigned RxBytesMax = 16;
  localparam int unsigned TxIdxW     = $clog2(TxBytesMax);

  // configuration register map
  localparam int unsigned CfgAddrW     = 3;
  localparam logic [0:0]  CfgIdxTicks  = 1'b0;
  localparam logic [7:0]  TicksReset   = 8'd125;

  // command codes
  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdStart = 2'd1,
    CmdTick  = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  // bus phases
  typedef enum logic [2:0] {
    PhIdle      = 3'd0,
    PhTx        = 3'd1,
    PhStop      = 3'd2,
    PhWaitRise  = 3'd3,
    PhWaitStart = 3'd4,
    PhSample    = 3'd5,
    PhBitLow    = 3'd6,
    PhBitHigh   = 3'd7
  } phase_e;

endpackage

// ----- hw/rtl/joybus_host_transfer.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        to block   in_valid_i / in_ready_o   command_i tx_byte_i tx_length_i rx_length_i
//                                                line_in_i
// out       from block out_valid_o / out_ready_i drive_low_o rx_byte_o rx_byte_valid_o
//                                                rx_byte_index_o done_res_o bits_received_o
//                                                busy_res_o
// cfg       to block   psel penable pwrite       paddr pwdata prdata (pready tied high)
//
// one item per clock unless the output stalls: the bus state registers update at the
// accepting edge and the result lands in the output register at that same edge.
// in_ready_o stays high while the output register is empty or being drained, so with
// out_ready_i high an item enters every cycle; a stalled output holds one result.
// reset clears all control state and loads ticks_per_us with 125; the transmit queue
// holds no defined data until loaded.

module joybus_host_transfer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic [7:0]                    tx_byte_i,
  input  logic [3:0]                    tx_length_i,
  input  logic [4:0]                    rx_length_i,
  input  logic                          line_in_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          drive_low_o,
  output logic [7:0]                    rx_byte_o,
  output logic                          rx_byte_valid_o,
  output logic [3:0]                    rx_byte_index_o,
  output logic                          done_res_o,
  output logic [7:0]                    bits_received_o,
  output logic                          busy_res_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jbht_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import jbht_pkg::*;

  logic [7:0]        ticks_q;
  logic [7:0]        tx_buf_q [TxBytesMax];
  logic [3:0]        load_cnt_q, load_cnt_d;
  phase_e            phase_q, phase_d;
  logic [15:0]       timer_q, timer_d;
  logic [6:0]        tx_idx_q, tx_idx_d;
  logic [3:0]        send_len_q, send_len_d;
  logic [4:0]        reply_len_q, reply_len_d;
  logic [7:0]        rx_cnt_q, rx_cnt_d;
  logic [7:0]        rx_shift_q, rx_shift_d;
  logic              out_valid_q;
  logic              drive_q, drive_d;
  logic [7:0]        byte_q, byte_d;
  logic              bvalid_q, bvalid_d;
  logic [3:0]        bindex_q, bindex_d;
  logic              done_q, done_d;
  logic [7:0]        bits_q, bits_d;
  logic              busy_q;

  logic              accept;
  logic              cfg_wr;
  cmd_e              cmd;
  logic              start_go;
  logic              load_go;
  logic              is_tick;
  logic [3:0]        send_len_n;
  logic [4:0]        reply_len_n;

  logic [15:0]       us1, us2, us3, us4, us6, us8, us200;
  logic [15:0]       timer_sat;
  logic [3:0]        byte_pos;
  logic [7:0]        cur_byte;
  logic              cur_bit;
  logic              drive_cur;
  logic [6:0]        tx_idx_inc;
  logic              tx_step, tx_last, stop_step;
  logic              rise_to, start_to, sample_now, low_to, high_to;
  logic [7:0]        rx_limit;
  logic              at_limit;
  logic              fin_tick;
  logic [7:0]        fin_data;
  logic [7:0]        samp_mask;
  logic [7:0]        shift_new;

  // handshakes
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(command_i);
  assign is_tick    = accept && (cmd == CmdTick);
  assign start_go   = accept && (cmd == CmdStart) && (phase_q == PhIdle);
  assign load_go    = accept && (cmd == CmdLoad) && (phase_q == PhIdle)
                      && (load_cnt_q < 4'(TxBytesMax));

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CfgIdxTicks);
  assign prdata = (paddr[2] == CfgIdxTicks) ? {24'd0, ticks_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= TicksReset;
    end else if (cfg_wr) begin
      ticks_q <= pwdata[7:0];
    end
  end

  // scaled bus timings
  assign us1   = {8'd0, ticks_q};
  assign us2   = us1 << 1;
  assign us3   = us1 + us2;
  assign us4   = us1 << 2;
  assign us6   = us3 << 1;
  assign us8   = us1 << 3;
  assign us200 = (us1 << 7) + (us1 << 6) + (us1 << 3);

  // saturated lengths for a start
  assign send_len_n  = tx_length_i[3] ? 4'(TxBytesMax) : tx_length_i;
  assign reply_len_n = (rx_length_i >= 5'(RxBytesMax)) ? 5'(RxBytesMax) : rx_length_i;

  // current transmit bit and line level
  assign byte_pos  = tx_idx_q[6:3];
  assign cur_byte  = (byte_pos < 4'(TxBytesMax)) ? tx_buf_q[byte_pos[TxIdxW-1:0]] : 8'd0;
  assign cur_bit   = cur_byte[3'd7 - tx_idx_q[2:0]];

  always_comb begin
    drive_cur = 1'b0;
    case (phase_q)
      PhTx:    drive_cur = timer_q < (cur_bit ? us1 : us3);
      PhStop:  drive_cur = timer_q < us1;
      default: drive_cur = 1'b0;
    endcase
  end

  // phase conditions
  assign timer_sat  = (timer_q == 16'hFFFF) ? timer_q : timer_q + 16'd1;
  assign tx_idx_inc = tx_idx_q + 7'd1;
  assign tx_step    = timer_sat >= us4;
  assign tx_last    = tx_idx_inc >= {send_len_q, 3'b000};
  assign stop_step  = timer_sat >= us1;
  assign rise_to    = timer_q > us2;
  assign start_to   = timer_q > us200;
  assign sample_now = timer_q >= us2;
  assign low_to     = timer_q > us6;
  assign high_to    = timer_q > us8;
  assign rx_limit   = {reply_len_q, 3'b000};
  assign at_limit   = rx_cnt_q >= (rx_limit + 8'd1);

  always_comb begin
    fin_tick = 1'b0;
    case (phase_q)
      PhWaitRise:  fin_tick = !line_in_i && rise_to;
      PhWaitStart: fin_tick = line_in_i && start_to;
      PhBitLow:    fin_tick = !line_in_i && low_to;
      PhBitHigh:   fin_tick = line_in_i ? high_to : at_limit;
      default:     fin_tick = 1'b0;
    endcase
  end

  // reply bit packing
  assign fin_data  = (rx_cnt_q < rx_limit) ? rx_cnt_q : rx_limit;
  assign samp_mask = 8'h80 >> rx_cnt_q[2:0];
  assign shift_new = line_in_i ? (rx_shift_q | samp_mask) : rx_shift_q;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (start_go) begin
      phase_d = (send_len_n != 4'd0) ? PhTx : PhStop;
    end else if (is_tick) begin
      case (phase_q)
        PhTx:        if (tx_step && tx_last) phase_d = PhStop;
        PhStop:      if (stop_step) phase_d = PhWaitRise;
        PhWaitRise:  if (line_in_i) phase_d = PhWaitStart;
        PhWaitStart: if (!line_in_i) phase_d = PhSample;
        PhSample:    if (sample_now) phase_d = PhBitLow;
        PhBitLow:    if (line_in_i) phase_d = PhBitHigh;
        PhBitHigh:   if (!line_in_i) phase_d = PhSample;
        default:     phase_d = phase_q;
      endcase
      if (fin_tick) begin
        phase_d = PhIdle;
      end
    end
  end

  // datapath and result
  always_comb begin
    load_cnt_d  = load_cnt_q;
    timer_d     = timer_q;
    tx_idx_d    = tx_idx_q;
    send_len_d  = send_len_q;
    reply_len_d = reply_len_q;
    rx_cnt_d    = rx_cnt_q;
    rx_shift_d  = rx_shift_q;
    drive_d     = drive_cur;
    byte_d      = 8'd0;
    bvalid_d    = 1'b0;
    bindex_d    = 4'd0;
    done_d      = 1'b0;
    bits_d      = 8'd0;

    if (load_go) begin
      load_cnt_d = load_cnt_q + 4'd1;
    end

    if (start_go) begin
      send_len_d  = send_len_n;
      reply_len_d = reply_len_n;
      timer_d     = 16'd0;
      tx_idx_d    = 7'd0;
      rx_cnt_d    = 8'd0;
      rx_shift_d  = 8'd0;
      load_cnt_d  = 4'd0;
      // first cell or stop pulse starts low unless every timing is zero
      drive_d     = (ticks_q != 8'd0);
    end

    if (is_tick) begin
      case (phase_q)
        PhTx: begin
          timer_d = timer_sat;
          if (tx_step) begin
            timer_d  = 16'd0;
            tx_idx_d = tx_idx_inc;
          end
        end
        PhStop: begin
          timer_d = stop_step ? 16'd0 : timer_sat;
        end
        PhWaitRise, PhBitLow: begin
          timer_d = timer_sat;
        end
        PhWaitStart: begin
          timer_d = line_in_i ? timer_sat : 16'd1;
        end
        PhSample: begin
          timer_d = timer_sat;
          if (sample_now) begin
            rx_cnt_d = rx_cnt_q + 8'd1;
            if (rx_cnt_q < rx_limit) begin
              rx_shift_d = shift_new;
              if (rx_cnt_q[2:0] == 3'd7) begin
                byte_d     = shift_new;
                bvalid_d   = 1'b1;
                bindex_d   = rx_cnt_q[6:3];
                rx_shift_d = 8'd0;
              end
            end
          end
        end
        PhBitHigh: begin
          timer_d = line_in_i ? timer_sat : 16'd1;
        end
        default: begin
          timer_d = timer_q;
        end
      endcase

      // end of transfer with any partial byte
      if (fin_tick) begin
        done_d  = 1'b1;
        bits_d  = rx_cnt_q;
        timer_d = 16'd0;
        if (fin_data[2:0] != 3'd0) begin
          byte_d     = rx_shift_q;
          bvalid_d   = 1'b1;
          bindex_d   = fin_data[6:3];
          rx_shift_d = 8'd0;
        end
      end
    end
  end

  // bus state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= 4'd0;
      phase_q     <= PhIdle;
      timer_q     <= 16'd0;
      tx_idx_q    <= 7'd0;
      send_len_q  <= 4'd0;
      reply_len_q <= 5'd0;
      rx_cnt_q    <= 8'd0;
      rx_shift_q  <= 8'd0;
    end else if (accept) begin
      load_cnt_q  <= load_cnt_d;
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      tx_idx_q    <= tx_idx_d;
      send_len_q  <= send_len_d;
      reply_len_q <= reply_len_d;
      rx_cnt_q    <= rx_cnt_d;
      rx_shift_q  <= rx_shift_d;
    end
  end

  // transmit queue
  always_ff @(posedge clk_i) begin
    if (load_go) begin
      tx_buf_q[load_cnt_q[TxIdxW-1:0]] <= tx_byte_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drive_q  <= drive_d;
      byte_q   <= byte_d;
      bvalid_q <= bvalid_d;
      bindex_q <= bindex_d;
      done_q   <= done_d;
      bits_q   <= bits_d;
      busy_q   <= (phase_d != PhIdle);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_low_o     = drive_q;
  assign rx_byte_o       = byte_q;
  assign rx_byte_valid_o = bvalid_q;
  assign rx_byte_index_o = bindex_q;
  assign done_res_o      = done_q;
  assign bits_received_o = bits_q;
  assign busy_res_o      = busy_q;

endmodule

// ----- hw/rtl/jbht_checker.sv -----
`timescale 1ns / 1ps

module jbht_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic                          drive_low_o,
  input  logic [7:0]                    rx_byte_o,
  input  logic                          rx_byte_valid_o,
  input  logic [3:0]                    rx_byte_index_o,
  input  logic                          done_res_o,
  input  logic [7:0]                    bits_received_o,
  input  logic                          busy_res_o
);
  import jbht_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a finished transfer leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while still busy");

  // the line is only pulled low during a transfer
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_low_o |-> busy_res_o)
    else $error("line driven low while idle");

  // byte and count fields are zero when not reported
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rx_byte_valid_o || (rx_byte_o == 8'd0 && rx_byte_index_o == 4'd0))
                    && (done_res_o || bits_received_o == 8'd0))
    else $error("stale reply fields");

  // only a tick can finish a transfer
  a_done_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i != CmdTick) |=> !(out_valid_o && done_res_o))
    else $error("transfer ended without a tick");

endmodule

bind joybus_host_transfer jbht_checker u_jbht_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .command_i       (command_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .drive_low_o     (drive_low_o),
  .rx_byte_o       (rx_byte_o),
  .rx_byte_valid_o (rx_byte_valid_o),
  .rx_byte_index_o (rx_byte_index_o),
  .done_res_o      (done_res_o),
  .bits_received_o (bits_received_o),
  .busy_res_o      (busy_res_o)
);

// ----- tb/joybus_host_transfer_test.sv -----
`timescale 1ns / 1ps

module joybus_host_transfer_test;
  import jbht_pkg::*;

  localparam logic [CfgAddrW-1:0] TicksAddr = CfgAddrW'(4 * CfgIdxTicks);
  localparam int unsigned StopAfterNs = 40_000_000;

  // shape of the device reply that the line emulation plays back
  typedef enum int unsigned {
    ReplyFull,
    ReplyShort,
    ReplyRandom,
    ReplyNoRise,
    ReplyNoStart,
    ReplyStuckLow
  } reply_kind_e;

  typedef struct packed {
    logic       drive;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic [3:0] rx_index;
    logic       done;
    logic [7:0] rx_bits;
    logic       busy;
  } bus_result_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [1:0] command_i     = CmdNone;
  logic [7:0] tx_byte_i     = 8'h00;
  logic [3:0] tx_length_i   = 4'h0;
  logic [4:0] rx_length_i   = 5'h00;
  logic       line_in_i     = 1'b1;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic       drive_low_o;
  logic [7:0] rx_byte_o;
  logic       rx_byte_valid_o;
  logic [3:0] rx_byte_index_o;
  logic       done_res_o;
  logic [7:0] bits_received_o;
  logic       busy_res_o;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [CfgAddrW-1:0] paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;

  joybus_host_transfer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .tx_byte_i       (tx_byte_i),
    .tx_length_i     (tx_length_i),
    .rx_length_i     (rx_length_i),
    .line_in_i       (line_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_low_o     (drive_low_o),
    .rx_byte_o       (rx_byte_o),
    .rx_byte_valid_o (rx_byte_valid_o),
    .rx_byte_index_o (rx_byte_index_o),
    .done_res_o      (done_res_o),
    .bits_received_o (bits_received_o),
    .busy_res_o      (busy_res_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #(StopAfterNs);
    $display("CHECKS FAILED");
    $finish;
  end

  // predicted bus state
  logic [7:0]  tq_buf [TxBytesMax];
  int unsigned tq_count;
  int unsigned tq_written;
  phase_e      ph;
  int unsigned ph_timer;
  int unsigned tx_bit_idx;
  int unsigned send_len;
  int unsigned reply_len;
  int unsigned rx_count;
  logic [7:0]  rx_sh;
  logic [7:0]  cfg_tpu;

  bus_result_t pred;
  bus_result_t want;
  bus_result_t pending_bus_results[$];

  int unsigned mismatch_count;
  int unsigned items_accepted;
  int unsigned valid_idle_pct;
  int unsigned ready_idle_pct;
  int          hold_off_left;

  function automatic void reset_bus_model();
    tq_count   = 0;
    tq_written = 0;
    ph         = PhIdle;
    ph_timer   = 0;
    tx_bit_idx = 0;
    send_len   = 0;
    reply_len  = 0;
    rx_count   = 0;
    rx_sh      = 8'h00;
    cfg_tpu    = TicksReset;
  endfunction

  function automatic logic tx_bit_now();
    logic [7:0] b;
    b = 8'h00;
    if ((tx_bit_idx / 8) < TxBytesMax) b = tq_buf[tx_bit_idx / 8];
    return b[7 - (tx_bit_idx % 8)];
  endfunction

  // level the current phase calls for
  function automatic logic line_drive_now();
    int unsigned us;
    us = cfg_tpu;
    if (ph == PhTx) return ph_timer < (tx_bit_now() ? us : 3 * us);
    if (ph == PhStop) return ph_timer < us;
    return 1'b0;
  endfunction

  function automatic void bump_timer();
    if (ph_timer < 16'hFFFF) ph_timer++;
  endfunction

  function automatic void emit_rx_data(int unsigned index);
    pred.rx_data  = rx_sh;
    pred.rx_valid = 1'b1;
    pred.rx_index = 4'(index);
    rx_sh         = 8'h00;
  endfunction

  // end of transfer, flushes any partial byte
  function automatic void end_transfer();
    int unsigned data_bits;
    data_bits    = (rx_count < reply_len * 8) ? rx_count : reply_len * 8;
    pred.done    = 1'b1;
    pred.rx_bits = 8'(rx_count);
    if (data_bits % 8 != 0) emit_rx_data(data_bits / 8);
    ph       = PhIdle;
    ph_timer = 0;
  endfunction

  function automatic void take_sample(logic lvl);
    if (rx_count < reply_len * 8) begin
      if (lvl) rx_sh[7 - (rx_count % 8)] = 1'b1;
      if (rx_count % 8 == 7) emit_rx_data(rx_count / 8);
    end
    rx_count++;
  endfunction

  function automatic void bus_tick(logic lvl);
    int unsigned us;
    us = cfg_tpu;
    pred.drive = line_drive_now();
    case (ph)
      PhTx: begin
        bump_timer();
        if (ph_timer >= 4 * us) begin
          ph_timer = 0;
          tx_bit_idx++;
          if (tx_bit_idx >= send_len * 8) ph = PhStop;
        end
      end
      PhStop: begin
        bump_timer();
        if (ph_timer >= us) begin
          ph       = PhWaitRise;
          ph_timer = 0;
        end
      end
      PhWaitRise: begin
        if (lvl) begin
          ph = PhWaitStart;
          bump_timer();
        end else if (ph_timer > 2 * us) end_transfer();
        else bump_timer();
      end
      PhWaitStart: begin
        if (!lvl) begin
          ph       = PhSample;
          ph_timer = 1;
        end else if (ph_timer > 200 * us) end_transfer();
        else bump_timer();
      end
      PhSample: begin
        if (ph_timer >= 2 * us) begin
          take_sample(lvl);
          ph = PhBitLow;
        end
        bump_timer();
      end
      PhBitLow: begin
        if (lvl) begin
          ph = PhBitHigh;
          bump_timer();
        end else if (ph_timer > 6 * us) end_transfer();
        else bump_timer();
      end
      PhBitHigh: begin
        if (!lvl) begin
          if (rx_count >= reply_len * 8 + 1) end_transfer();
          else begin
            ph       = PhSample;
            ph_timer = 1;
          end
        end else if (ph_timer > 8 * us) end_transfer();
        else bump_timer();
      end
      default: ;
    endcase
  endfunction

  // expected result of one accepted transaction
  function automatic void predict_bus_item(cmd_e cmd, logic [7:0] txb, logic [3:0] txl,
                                           logic [4:0] rxl, logic lvl);
    pred = '0;
    case (cmd)
      CmdLoad: begin
        if (ph == PhIdle && tq_count < TxBytesMax) begin
          tq_buf[tq_count] = txb;
          tq_count++;
          if (tq_count > tq_written) tq_written = tq_count;
        end
        pred.drive = line_drive_now();
      end
      CmdStart: begin
        if (ph == PhIdle) begin
          send_len   = (txl < TxBytesMax) ? txl : TxBytesMax;
          reply_len  = (rxl < RxBytesMax) ? rxl : RxBytesMax;
          ph         = (send_len != 0) ? PhTx : PhStop;
          ph_timer   = 0;
          tx_bit_idx = 0;
          rx_count   = 0;
          rx_sh      = 8'h00;
          tq_count   = 0;
        end
        pred.drive = line_drive_now();
      end
      CmdTick: bus_tick(lvl);
      default: pred.drive = line_drive_now();
    endcase
    pred.busy = (ph != PhIdle);
    pending_bus_results.push_back(pred);
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      if (mismatch_count < 50)
        $display("%0t ns: %s expected %0h actual %0h", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  // result side: random ready, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_ready_i <= 1'b0;
      hold_off_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= ready_idle_pct);
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bus_results.size() == 0) begin
        if (mismatch_count < 50) $display("%0t ns: result with none expected", $time);
        mismatch_count++;
      end else begin
        want = pending_bus_results.pop_front();
        check_field("drive_low", want.drive, drive_low_o);
        check_field("rx_byte", want.rx_data, rx_byte_o);
        check_field("rx_byte_valid", want.rx_valid, rx_byte_valid_o);
        check_field("rx_byte_index", want.rx_index, rx_byte_index_o);
        check_field("done_res", want.done, done_res_o);
        check_field("bits_received", want.rx_bits, bits_received_o);
        check_field("busy_res", want.busy, busy_res_o);
      end
    end
  end

  // one input transaction, entered and left at a falling edge
  task automatic send_item(cmd_e cmd, logic [7:0] txb, logic [3:0] txl, logic [4:0] rxl,
                           logic lvl);
    while ($urandom_range(99) < valid_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    tx_byte_i   <= txb;
    tx_length_i <= txl;
    rx_length_i <= rxl;
    line_in_i   <= lvl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_bus_item(cmd, txb, txl, rxl, lvl);
    items_accepted++;
    @(negedge clk_i);
  endtask

  task automatic send_tick(logic lvl);
    send_item(CmdTick, 8'($urandom), 4'($urandom), 5'($urandom), lvl);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_bus_results.size() != 0);
  endtask

  // one register write or read-back of ticks_per_us
  task automatic apb_access(logic wr, logic [7:0] value);
    psel    <= 1'b1;
    pwrite  <= wr;
    penable <= 1'b0;
    paddr   <= TicksAddr;
    pwdata  <= {24'h0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (wr) cfg_tpu = value;
    else if (prdata !== {24'h0, value}) begin
      $display("%0t ns: ticks_per_us read expected %0h actual %0h", $time, value, prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_ticks_per_us(logic [7:0] value);
    wait_results_drained();
    apb_access(1'b1, value);
    apb_access(1'b0, value);
  endtask

  // loads, start, then ticks with a device reply played on the line until idle
  task automatic run_transfer(int unsigned n_loads, logic [3:0] txl, logic [4:0] rxl,
                              reply_kind_e kind);
    int unsigned us;
    int unsigned tx_sat;
    int unsigned n_bits;
    int unsigned low_t;
    int unsigned high_t;
    int unsigned pick;
    logic        bit_v;
    logic        lvl;
    logic        line_plan[$];
    us = cfg_tpu;
    for (int i = 0; i < n_loads; i++)
      send_item(CmdLoad, 8'($urandom), 4'($urandom), 5'($urandom), 1'($urandom));
    // never send a queue entry that was never loaded
    tx_sat = (txl > TxBytesMax) ? TxBytesMax : txl;
    if (tx_sat > tq_written) txl = 4'(tq_written);
    if ($urandom_range(4) == 0) send_item(CmdNone, 8'($urandom), 4'($urandom),
                                          5'($urandom), 1'($urandom));
    if ($urandom_range(4) == 0) send_tick(1'($urandom));
    send_item(CmdStart, 8'($urandom), txl, rxl, 1'($urandom));

    // commands while busy are dropped
    pick = $urandom_range(2);
    if (pick == 0) send_item(CmdLoad, 8'($urandom), 4'($urandom), 5'($urandom), 1'b1);
    else if (pick == 1) send_item(CmdStart, 8'($urandom), 4'($urandom), 5'($urandom), 1'b1);
    else send_item(CmdNone, 8'($urandom), 4'($urandom), 5'($urandom), 1'b1);

    // transmit and stop pulse, line follows our own drive
    while (ph == PhTx || ph == PhStop) begin
      if ($urandom_range(99) < 4)
        send_item(($urandom_range(1) == 0) ? CmdLoad : CmdStart, 8'($urandom),
                  4'($urandom), 5'($urandom), 1'($urandom));
      else
        send_tick(!line_drive_now());
    end

    // device reply waveform
    if (kind == ReplyNoRise) begin
      for (int i = 0; i < 2 * us + 3; i++) line_plan.push_back(1'b0);
    end else begin
      for (int i = 0; i < $urandom_range(2 * us); i++) line_plan.push_back(1'b0);
    end
    if (kind != ReplyNoStart && kind != ReplyNoRise) begin
      for (int i = 0; i < $urandom_range(1, 3 * us + 1); i++) line_plan.push_back(1'b1);
      if (kind == ReplyFull) n_bits = reply_len * 8 + 1;
      else if (kind == ReplyRandom) n_bits = $urandom_range(reply_len * 8 + 3);
      else n_bits = $urandom_range(reply_len * 8 + 1);
      for (int b = 0; b < n_bits; b++) begin
        bit_v = (kind == ReplyFull && b == n_bits - 1) ? 1'b1 : 1'($urandom);
        low_t = bit_v ? us : 3 * us;
        if (us >= 4) low_t = low_t - us / 4 + $urandom_range(us / 2);
        if (low_t == 0) low_t = 1;
        high_t = (4 * us > low_t) ? 4 * us - low_t : 1;
        if (us >= 4) high_t = high_t - us / 4 + $urandom_range(us / 2);
        if (kind == ReplyRandom && $urandom_range(19) == 0) high_t = 8 * us + 2;
        for (int i = 0; i < low_t; i++) line_plan.push_back(1'b0);
        for (int i = 0; i < high_t; i++) line_plan.push_back(1'b1);
      end
      if (kind == ReplyStuckLow) begin
        for (int i = 0; i < 6 * us + 3; i++) line_plan.push_back(1'b0);
      end else if ($urandom_range(1) == 0) begin
        // an extra fall ends a full reply before the idle timeout
        for (int i = 0; i < (us > 0 ? us : 1); i++) line_plan.push_back(1'b0);
      end
    end

    while (ph != PhIdle) begin
      lvl = 1'b1;
      if (line_plan.size() != 0) lvl = line_plan.pop_front();
      if (kind == ReplyRandom && $urandom_range(49) == 0) lvl = !lvl;
      send_tick(lvl);
    end
  endtask

  // idle behavior at the reset setting, queue limits
  task automatic test_idle_commands();
    logic [7:0] fill[9];
    fill = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h3C, 8'hC3, 8'h77};
    apb_access(1'b0, TicksReset);
    send_tick(1'b0);
    send_tick(1'b1);
    send_item(CmdNone, 8'hFF, 4'hF, 5'h1F, 1'b1);
    send_item(CmdNone, 8'h00, 4'h0, 5'h00, 1'b0);
    // the ninth load finds the queue full
    foreach (fill[i]) send_item(CmdLoad, fill[i], 4'($urandom), 5'($urandom), 1'($urandom));
  endtask

  // short transfers at one tick per microsecond
  task automatic test_short_transfers();
    set_ticks_per_us(8'd1);
    run_transfer(0, 4'd0, 5'd0, ReplyFull);
    run_transfer(9, 4'd15, 5'd31, ReplyFull);
    run_transfer(8, 4'd8, 5'd16, ReplyFull);
    run_transfer(2, 4'd2, 5'd2, ReplyShort);
    run_transfer(1, 4'd1, 5'd1, ReplyNoRise);
    run_transfer(1, 4'd1, 5'd1, ReplyNoStart);
    run_transfer(1, 4'd1, 5'd2, ReplyStuckLow);
  endtask

  // slowest and degenerate timing
  task automatic test_timing_extremes();
    set_ticks_per_us(8'd255);
    run_transfer(0, 4'd0, 5'd1, ReplyFull);
    set_ticks_per_us(8'd0);
    run_transfer(1, 4'd1, 5'd1, ReplyFull);
    run_transfer(0, 4'd0, 5'd2, ReplyRandom);
  endtask

  // random transfers under one idling pattern
  task automatic test_random_traffic(int unsigned snd_pct, int unsigned rcv_pct,
                                     int unsigned n_items, bit with_hold);
    int unsigned stop_at;
    int unsigned loads;
    int unsigned pick;
    logic [3:0]  txl;
    logic [4:0]  rxl;
    reply_kind_e kind;
    set_ticks_per_us(8'($urandom_range(1, 4)));
    valid_idle_pct = snd_pct;
    ready_idle_pct = rcv_pct;
    stop_at = items_accepted + n_items;
    while (items_accepted < stop_at) begin
      if ($urandom_range(3) == 0) set_ticks_per_us(8'($urandom_range(1, 4)));
      txl = ($urandom_range(9) < 7) ? 4'($urandom_range(2)) : 4'($urandom);
      rxl = ($urandom_range(9) < 7) ? 5'($urandom_range(3)) : 5'($urandom);
      loads = ($urandom_range(3) == 0) ? $urandom_range(9) : txl + $urandom_range(1);
      pick = $urandom_range(99);
      if (pick < 55) kind = ReplyFull;
      else if (pick < 70) kind = ReplyShort;
      else if (pick < 85) kind = ReplyRandom;
      else if (pick < 90) kind = ReplyNoRise;
      else if (pick < 93) kind = ReplyNoStart;
      else kind = ReplyStuckLow;
      // long output stall while transactions keep coming
      if (with_hold) begin
        hold_off_left = 80;
        with_hold = 1'b0;
      end
      run_transfer(loads, txl, rxl, kind);
    end
  endtask

  // test sequence
  initial begin
    reset_bus_model();
    mismatch_count = 0;
    items_accepted = 0;
    valid_idle_pct = 0;
    ready_idle_pct = 0;
    hold_off_left  = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_idle_commands();
    test_short_transfers();
    test_timing_extremes();
    test_random_traffic(25, 79, 370, 1'b1);
    test_random_traffic(79, 25, 370, 1'b0);
    test_random_traffic(0, 0, 370, 1'b1);
    wait_results_drained();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
